// ----- hw/rtl/hnil_pkg.sv -----
package hnil_pkg;

	// Kind of an input word, carried on s_tuser.
	typedef enum logic [0:0] {
		ACT_LOAD = 1'b0,
		ACT_NAME = 1'b1
	} act_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_ENTRY_COUNT = 2'd0,
		CFG_DATA_BASE   = 2'd1,
		CFG_PACK_BYTES  = 2'd2,
		CFG_FOLD_CASE   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [8:0]  entry_count;
		logic [39:0] data_base;
		logic [39:0] pack_bytes;
		logic        fold_case;
	} cfg_t;

	typedef struct packed {
		logic [63:0] hash;
		logic [39:0] offset;
		logic [39:0] length;
	} entry_t;

	// Search request raised by the last byte of a name.
	typedef struct packed {
		logic        start;
		logic [63:0] digest;
	} srch_req_t;

	typedef struct packed {
		logic        found;
		logic        in_bounds;
		logic [40:0] data_start;
		logic [39:0] data_length;
		logic [63:0] name_digest;
	} result_t;

	typedef enum logic [2:0] {
		SRCH_IDLE,
		SRCH_SCAN,
		SRCH_CALC,
		SRCH_CHECK,
		SRCH_DONE
	} srch_state_t;

endpackage

// ----- hw/rtl/hnil_hash.sv -----
module hnil_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_en,
	input  logic        last,
	input  logic        fold_case,
	input  logic [7:0]  name_char,
	output logic [63:0] digest
);
	localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
	// Prime is 2^40 + 0x1B3: one shift plus a narrow constant product.
	localparam logic [63:0] FNV_PRIME_LO = 64'h1B3;
	localparam logic [7:0]  CH_BSLASH = 8'h5C;
	localparam logic [7:0]  CH_SLASH  = 8'h2F;
	localparam logic [7:0]  CH_UP_A   = 8'h41;
	localparam logic [7:0]  CH_UP_Z   = 8'h5A;
	localparam logic [7:0]  CASE_GAP  = 8'h20;

	logic [63:0] running_q;
	logic [7:0]  norm;
	logic [63:0] mixed;

	always_comb begin
		norm = name_char;
		if (norm == CH_BSLASH) begin
			norm = CH_SLASH;
		end
		if (fold_case && norm >= CH_UP_A && norm <= CH_UP_Z) begin
			norm = norm + CASE_GAP;
		end
		mixed  = running_q ^ {56'd0, norm};
		digest = (mixed << 40) + (mixed * FNV_PRIME_LO);
	end

	// Restart at the basis after the last byte of a name.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= FNV_BASIS;
		end else if (byte_en) begin
			running_q <= last ? FNV_BASIS : digest;
		end
	end

endmodule

// ----- hw/rtl/hnil_table.sv -----
module hnil_table #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  hnil_pkg::entry_t      wr_entry,
	input  logic                  rd_en,
	input  logic [ADDR_W-1:0]     rd_addr,
	output hnil_pkg::entry_t      rd_entry
);
	import hnil_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry <= mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/hnil_search.sv -----
module hnil_search #(
	parameter int MAX_ENTRIES = 256,
	parameter int ADDR_W      = 8,
	parameter int CNT_W       = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hnil_pkg::cfg_t        cfg,
	input  hnil_pkg::srch_req_t   req,
	output logic                  idle,
	output logic                  rd_en,
	output logic [ADDR_W-1:0]     rd_addr,
	input  hnil_pkg::entry_t      rd_entry,
	output logic                  res_valid,
	input  logic                  res_ready,
	output hnil_pkg::result_t     res
);
	import hnil_pkg::*;

	srch_state_t      state_q, state_d;
	logic [63:0]      digest_q;
	logic [CNT_W-1:0] limit_q, limit_d, addr_q;
	logic             pend_s1;
	logic             found_q;
	logic [39:0]      off_q, len_q;
	logic [40:0]      start_q;
	logic             inb_q;
	logic             more, hit, scan_end, out_free;
	logic [31:0]      cnt_ext;

	assign cnt_ext  = 32'(cfg.entry_count);
	assign limit_d  = (cnt_ext > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : CNT_W'(cnt_ext);
	assign more     = addr_q < limit_q;
	assign hit      = pend_s1 && (rd_entry.hash == digest_q);
	assign out_free = !res_valid || res_ready;
	assign rd_addr  = addr_q[ADDR_W-1:0];

	always_comb begin
		state_d  = state_q;
		idle     = 1'b0;
		rd_en    = 1'b0;
		scan_end = 1'b0;
		unique case (state_q)
			SRCH_IDLE: begin
				idle = 1'b1;
				if (req.start) begin
					state_d = SRCH_SCAN;
				end
			end
			SRCH_SCAN: begin
				rd_en    = more;
				scan_end = !pend_s1 && !more;
				if (hit || scan_end) begin
					state_d = SRCH_CALC;
				end
			end
			SRCH_CALC:  state_d = SRCH_CHECK;
			SRCH_CHECK: state_d = SRCH_DONE;
			SRCH_DONE: begin
				if (out_free) begin
					state_d = SRCH_IDLE;
				end
			end
			default: state_d = SRCH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SRCH_IDLE;
			pend_s1   <= 1'b0;
			found_q   <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= rd_en;
			if (state_q == SRCH_IDLE && req.start) begin
				found_q <= 1'b0;
			end else if (state_q == SRCH_SCAN && hit) begin
				found_q <= 1'b1;
			end
			if (state_q == SRCH_DONE && out_free) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SRCH_IDLE && req.start) begin
			digest_q <= req.digest;
			limit_q  <= limit_d;
			addr_q   <= '0;
			off_q    <= '0;
			len_q    <= '0;
		end
		if (rd_en) begin
			addr_q <= addr_q + CNT_W'(1);
		end
		if (state_q == SRCH_SCAN && hit) begin
			off_q <= rd_entry.offset;
			len_q <= rd_entry.length;
		end
		if (state_q == SRCH_CALC) begin
			start_q <= found_q ? ({1'b0, cfg.data_base} + {1'b0, off_q}) : '0;
		end
		if (state_q == SRCH_CHECK) begin
			inb_q <= found_q && (({1'b0, start_q} + {2'b00, len_q}) <= {2'b00, cfg.pack_bytes});
		end
		if (state_q == SRCH_DONE && out_free) begin
			res.found       <= found_q;
			res.in_bounds   <= inb_q;
			res.data_start  <= start_q;
			res.data_length <= len_q;
			res.name_digest <= digest_q;
		end
	end

endmodule

// ----- hw/rtl/hashed_name_index_lookup.sv -----
// Hashed name index lookup. The block holds an index table of up to MAX_ENTRIES
// entries (64-bit FNV-1a name hash, 40-bit offset relative to data_base, 40-bit size)
// in one synchronous memory. An input word with tuser = load writes the entry at
// slot (slots at or above MAX_ENTRIES are dropped). A word with tuser = name feeds
// one raw name byte: backslash becomes slash, A-Z folds to lower case if fold_case is
// set, and the byte enters a running FNV-1a 64 hash. Load words and name bytes
// without tlast are taken back to back while the search is idle and give no result.
// The name byte with tlast starts a scan of entries 0 .. entry_count-1 (entry_count
// capped at MAX_ENTRIES), one memory read per cycle; the first matching hash wins.
// That byte holds off the input until the search is idle again: the single read
// port of the index memory visits one entry per cycle, the scan is followed by the
// CALC and CHECK steps, and DONE waits for the previous result word to be taken.
// The result word reports found, in_bounds (set on a hit with data_start +
// data_length <= pack_bytes), data_start = data_base + offset, data_length and the
// digest; start and length are zero on a miss. The hash restarts at the offset
// basis after each name. Entries never written read as undefined, so load every
// entry below entry_count before a lookup. Configuration writes are taken any cycle
// (cfg_ready is tied high) and must only be issued while the block is idle.
module hashed_name_index_lookup #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	// input word stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [159:0]        s_tdata,  // slot[7:0], entry_hash, entry_offset,
	                                      // entry_length, name_char
	input  logic                s_tlast,  // name_end
	input  hnil_pkg::act_t      s_tuser,  // action
	// result word stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [151:0]        m_tdata,  // data_start[40:0], data_length, name_digest,
	                                      // zero fill
	output logic [1:0]          m_tuser,  // found, in_bounds
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  hnil_pkg::cfg_idx_t  cfg_index,
	input  logic [39:0]         cfg_data
);
	import hnil_pkg::*;

	localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

	cfg_t        cfg_q;
	logic        in_fire, name_fire, load_fire;
	logic [7:0]  slot;
	logic [31:0] slot_ext;
	logic        wr_en;
	entry_t      wr_entry, rd_entry;
	logic        rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [63:0] digest;
	srch_req_t   req;
	logic        srch_idle;
	result_t     res;

	// Input is held for the whole scan; loads and plain name bytes flow at one per cycle while the search is idle.
	assign s_tready  = srch_idle;
	assign cfg_ready = 1'b1;

	assign in_fire   = s_tvalid && s_tready;
	assign name_fire = in_fire && (s_tuser == ACT_NAME);
	assign load_fire = in_fire && (s_tuser == ACT_LOAD);

	assign slot     = s_tdata[7:0];
	assign slot_ext = 32'(slot);
	assign wr_en    = load_fire && (slot_ext < 32'(MAX_ENTRIES));
	assign wr_entry = '{hash: s_tdata[71:8], offset: s_tdata[111:72],
	                   length: s_tdata[151:112]};

	// Register file; each register keeps only its own width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ENTRY_COUNT: cfg_q.entry_count <= cfg_data[8:0];
				CFG_DATA_BASE:   cfg_q.data_base   <= cfg_data;
				CFG_PACK_BYTES:  cfg_q.pack_bytes  <= cfg_data;
				CFG_FOLD_CASE:   cfg_q.fold_case   <= cfg_data[0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	hnil_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (name_fire),
		.last      (s_tlast),
		.fold_case (cfg_q.fold_case),
		.name_char (s_tdata[159:152]),
		.digest    (digest)
	);

	// The last name byte hands its finished digest straight to the search.
	assign req = '{start: name_fire && s_tlast, digest: digest};

	hnil_table #(
		.DEPTH  (MAX_ENTRIES),
		.ADDR_W (ADDR_W)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (slot_ext[ADDR_W-1:0]),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry)
	);

	hnil_search #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.ADDR_W      (ADDR_W),
		.CNT_W       (CNT_W)
	) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req       (req),
		.idle      (srch_idle),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_entry  (rd_entry),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {7'd0, res.name_digest, res.data_length, res.data_start};
	assign m_tuser = {res.in_bounds, res.found};

	// A hit that is out of bounds is possible; in bounds without a hit is not.
	a_inb_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] || !m_tuser[1]))
		else $error("in_bounds set on a miss");

	// A miss reports zero start and zero length.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[80:0] == 81'd0))
		else $error("miss word carries start or length");

	// The last name byte always starts a scan that holds off the input.
	a_last_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == ACT_NAME) && s_tlast) |=> !s_tready)
		else $error("input taken right after the last name byte");

endmodule
